// ===== rtl/nv12_to_i420_crop_converter_top_defines.svh =====
// Assertion macros shared by the NV12 to I420 crop converter RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef NV12_TO_I420_CROP_CONVERTER_TOP_DEFINES_SVH
`define NV12_TO_I420_CROP_CONVERTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds
`define NVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nvc assertion failed");
// Check cons in the cycle after ante holds
`define NVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nvc assertion failed");
`else
`define NVC_ASSERT_NOW(lbl, ante, cons)
`define NVC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/nvc_pkg.sv =====
// Shared types, widths and codes for the NV12 to I420 crop converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package nvc_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int MAX_STRIDE = 8192;

  localparam int DIM_W    = 13;
  localparam int STRIDE_W = 14;
  localparam int BYTE_W   = 8;
  localparam int LOFF_W   = 24;
  localparam int COFF_W   = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Result queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODED_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_COLS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_ROWS     = 3'd5;

  // Destination plane codes
  localparam logic [1:0] PLANE_Y    = 2'd0;
  localparam logic [1:0] PLANE_U    = 2'd1;
  localparam logic [1:0] PLANE_V    = 2'd2;
  localparam logic [1:0] PLANE_NONE = 2'd3;

  // Frame status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef enum logic [1:0] {
    PH_LUMA   = 2'd0,
    PH_CHROMA = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Configuration seen by the counter logic
  typedef struct packed {
    logic [DIM_W-1:0]    frame_rows;
    logic [STRIDE_W-1:0] luma_stride;
    logic [STRIDE_W-1:0] chroma_stride;
    logic [DIM_W-1:0]    crop_cols;
    logic [DIM_W-1:0]    crop_rows;
    logic                geo_ok;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]        plane;
    logic [LOFF_W-1:0] dest_offset;
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_frame;
    logic [1:0]        status;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/nvc_cfg.sv =====
// Configuration registers and geometry check on their current values.
// Depends on nvc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nvc_cfg
  import nvc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  localparam logic [DIM_W-1:0]    MAX_DIM_V    = DIM_W'(MAX_DIM);
  localparam logic [STRIDE_W-1:0] MAX_STRIDE_V = STRIDE_W'(MAX_STRIDE);

  logic [DIM_W-1:0]    coded_width_r, frame_rows_r;
  logic [STRIDE_W-1:0] luma_stride_r, chroma_stride_r;
  logic [DIM_W-1:0]    crop_cols_r, crop_rows_r;
  logic                geo_ok;

  // Write the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coded_width_r   <= '0;
      frame_rows_r    <= '0;
      luma_stride_r   <= '0;
      chroma_stride_r <= '0;
      crop_cols_r     <= '0;
      crop_rows_r     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_CODED_WIDTH:   coded_width_r   <= wr_data[DIM_W-1:0];
        CFG_FRAME_ROWS:    frame_rows_r    <= wr_data[DIM_W-1:0];
        CFG_LUMA_STRIDE:   luma_stride_r   <= wr_data[STRIDE_W-1:0];
        CFG_CHROMA_STRIDE: chroma_stride_r <= wr_data[STRIDE_W-1:0];
        CFG_CROP_COLS:     crop_cols_r     <= wr_data[DIM_W-1:0];
        CFG_CROP_ROWS:     crop_rows_r     <= wr_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Validate geometry: nonzero even sizes up to MAX_DIM, crop inside coded size, strides in range
  always_comb begin
    geo_ok = 1'b1;
    if (coded_width_r == '0 || frame_rows_r == '0) geo_ok = 1'b0;
    if (crop_cols_r == '0 || crop_rows_r == '0) geo_ok = 1'b0;
    if (coded_width_r[0] | frame_rows_r[0] | crop_cols_r[0] | crop_rows_r[0])
      geo_ok = 1'b0;
    if (crop_cols_r > coded_width_r || crop_rows_r > frame_rows_r)
      geo_ok = 1'b0;
    if (luma_stride_r < STRIDE_W'(coded_width_r) || chroma_stride_r < STRIDE_W'(coded_width_r))
      geo_ok = 1'b0;
    if (coded_width_r > MAX_DIM_V || frame_rows_r > MAX_DIM_V) geo_ok = 1'b0;
    if (luma_stride_r > MAX_STRIDE_V || chroma_stride_r > MAX_STRIDE_V) geo_ok = 1'b0;
  end

  assign cfg.frame_rows    = frame_rows_r;
  assign cfg.luma_stride   = luma_stride_r;
  assign cfg.chroma_stride = chroma_stride_r;
  assign cfg.crop_cols     = crop_cols_r;
  assign cfg.crop_rows     = crop_rows_r;
  assign cfg.geo_ok        = geo_ok;

endmodule
`default_nettype wire

// ===== rtl/nvc_ctr.sv =====
// Source position counters and write/status generation for each source byte.
// Depends on nvc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "nv12_to_i420_crop_converter_top_defines.svh"
module nvc_ctr
  import nvc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [BYTE_W-1:0] pixel_byte,
  input  wire logic              is_final,
  input  cfg_t                   cfg,
  output logic [1:0]             nres,
  output res_t                   res0,
  output res_t                   res1
);

  phase_t              phase_r, phase_nxt;
  logic [DIM_W-1:0]    row_r, row_nxt;
  logic [DIM_W-1:0]    col_r, col_nxt;
  logic [LOFF_W-1:0]   luma_dest_r, luma_dest_nxt;
  logic [COFF_W-1:0]   chroma_dest_r, chroma_dest_nxt;

  logic [STRIDE_W-1:0] col_inc;
  logic [DIM_W:0]      row_inc;
  logic [DIM_W-1:0]    half_ch, half_vh;
  logic                wr_vld;
  res_t                wr_res, st_res;

  assign col_inc = STRIDE_W'(col_r) + STRIDE_W'(1);
  assign row_inc = (DIM_W+1)'(row_r) + (DIM_W+1)'(1);
  assign half_ch = cfg.frame_rows >> 1;
  assign half_vh = cfg.crop_rows >> 1;

  // Place the byte, build the write and advance the counters
  always_comb begin
    phase_nxt       = phase_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    luma_dest_nxt   = luma_dest_r;
    chroma_dest_nxt = chroma_dest_r;
    wr_vld          = 1'b0;
    wr_res          = '0;
    wr_res.out_byte = pixel_byte;
    if (cfg.geo_ok) begin
      case (phase_r)
        PH_LUMA: begin
          if (row_r < cfg.crop_rows && col_r < cfg.crop_cols) begin
            wr_vld             = 1'b1;
            wr_res.plane       = PLANE_Y;
            wr_res.dest_offset = luma_dest_r;
            luma_dest_nxt      = luma_dest_r + LOFF_W'(1);
          end
          col_nxt = col_inc[DIM_W-1:0];
          if (col_inc >= cfg.luma_stride) begin
            col_nxt = '0;
            row_nxt = row_inc[DIM_W-1:0];
            if (row_inc >= (DIM_W+1)'(cfg.frame_rows)) begin
              row_nxt   = '0;
              phase_nxt = PH_CHROMA;
            end
          end
        end
        PH_CHROMA: begin
          if (row_r < half_vh && col_r < cfg.crop_cols) begin
            wr_vld             = 1'b1;
            wr_res.dest_offset = LOFF_W'(chroma_dest_r);
            if (col_r[0]) begin
              wr_res.plane    = PLANE_V;
              chroma_dest_nxt = chroma_dest_r + COFF_W'(1);
            end else begin
              wr_res.plane = PLANE_U;
            end
          end
          col_nxt = col_inc[DIM_W-1:0];
          if (col_inc >= cfg.chroma_stride) begin
            col_nxt = '0;
            row_nxt = row_inc[DIM_W-1:0];
            if (row_inc >= (DIM_W+1)'(half_ch)) begin
              row_nxt   = '0;
              phase_nxt = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end

    // Status transaction on the last byte
    st_res              = '0;
    st_res.plane        = PLANE_NONE;
    st_res.end_of_frame = 1'b1;
    if (!cfg.geo_ok) begin
      st_res.status = ST_BAD;
    end else if (phase_nxt == PH_DONE) begin
      st_res.status = ST_OK;
    end else begin
      st_res.status = ST_SHORT;
    end

    // Write goes out ahead of status
    nres = 2'(wr_vld) + 2'(is_final);
    res0 = wr_vld ? wr_res : st_res;
    res1 = st_res;

    // Drop all position state after the last byte
    if (is_final) begin
      phase_nxt       = PH_LUMA;
      row_nxt         = '0;
      col_nxt         = '0;
      luma_dest_nxt   = '0;
      chroma_dest_nxt = '0;
    end
  end

  // Advance state only on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LUMA;
      row_r         <= '0;
      col_r         <= '0;
      luma_dest_r   <= '0;
      chroma_dest_r <= '0;
    end else if (acc) begin
      phase_r       <= phase_nxt;
      row_r         <= row_nxt;
      col_r         <= col_nxt;
      luma_dest_r   <= luma_dest_nxt;
      chroma_dest_r <= chroma_dest_nxt;
    end
  end

  `NVC_ASSERT_NEXT(a_final_clears, acc && is_final,
    phase_r == PH_LUMA && row_r == '0 && col_r == '0 && luma_dest_r == '0)
  `NVC_ASSERT_NEXT(a_bad_geo_holds, acc && !is_final && !cfg.geo_ok,
    $stable(row_r) && $stable(col_r) && $stable(luma_dest_r) && $stable(chroma_dest_r))
  `NVC_ASSERT_NOW(a_no_write_when_done, phase_r == PH_DONE, !wr_vld)

endmodule
`default_nettype wire

// ===== rtl/nvc_outq.sv =====
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on nvc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "nv12_to_i420_crop_converter_top_defines.svh"
module nvc_outq
  import nvc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] push_n,
  input  res_t            push0,
  input  res_t            push1,
  output logic            space_ok,
  output logic            deq_valid,
  input  wire logic       deq_ready,
  output res_t            deq_data
);

  res_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0] wr_ptr_p1;
  logic               pop;

  assign wr_ptr_p1 = wr_ptr_r + Q_PTR_W'(1);
  assign pop       = deq_valid && deq_ready;
  assign deq_valid = cnt_r != '0;
  assign deq_data  = mem[rd_ptr_r];
  assign space_ok  = cnt_r <= Q_CNT_W'(Q_DEPTH - 2);

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    cnt_nxt    = cnt_r + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `NVC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= Q_CNT_W'(Q_DEPTH))
  `NVC_ASSERT_NOW(a_no_overflow, push_n != 2'd0, cnt_r <= Q_CNT_W'(Q_DEPTH - 2))
  `NVC_ASSERT_NOW(a_ptr_track, 1'b1,
    (wr_ptr_r - rd_ptr_r) == cnt_r[Q_PTR_W-1:0])

endmodule
`default_nettype wire

// ===== rtl/nv12_to_i420_crop_converter_top.sv =====
// Top level of the NV12 to cropped I420 stream converter.
// Depends on nvc_pkg, nvc_cfg, nvc_ctr and nvc_outq.
`timescale 1ns / 1ps
`default_nettype none
// The converter takes one NV12 source byte per clock and emits Y/U/V write
// transactions for bytes inside the visible window, plus a status transaction
// (plane 3, end_of_frame set) on the byte marked final. Each accepted byte is
// placed by incremental row/column counters combinationally and its results
// land in a 4-entry result queue; in_ready is high while that queue has two
// free slots, so the block sustains one byte per clock as long as the sink
// takes one result per clock. A final byte that is also a write yields two
// results, the write ahead of the status. Configuration must be written
// while the block is idle; the geometry check works on the register values
// directly, so a byte accepted right after the last write already sees it.
// No clearing pass follows reset.
module nv12_to_i420_crop_converter_top
  import nvc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_pixel_byte,
  input  wire logic                  in_is_final,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_plane,
  output logic [LOFF_W-1:0]          out_dest_offset,
  output logic [BYTE_W-1:0]          out_out_byte,
  output logic                       out_end_of_frame,
  output logic [1:0]                 out_status,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  logic       in_acc;
  logic [1:0] nres;
  logic [1:0] push_n;
  res_t       res0, res1, deq_data;

  assign in_acc = in_valid && in_ready;
  assign push_n = in_acc ? nres : 2'd0;

  nvc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  nvc_ctr u_ctr (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .pixel_byte (in_pixel_byte),
    .is_final   (in_is_final),
    .cfg        (cfg),
    .nres       (nres),
    .res0       (res0),
    .res1       (res1)
  );

  nvc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .space_ok  (in_ready),
    .deq_valid (out_valid),
    .deq_ready (out_ready),
    .deq_data  (deq_data)
  );

  // Unpack the head result onto the ports
  assign out_plane        = deq_data.plane;
  assign out_dest_offset  = deq_data.dest_offset;
  assign out_out_byte     = deq_data.out_byte;
  assign out_end_of_frame = deq_data.end_of_frame;
  assign out_status       = deq_data.status;

endmodule
`default_nettype wire

// ===== bench/nvc_frame_checker.sv =====
// Scoreboard for the NV12 to I420 crop converter: follows register writes and source
// transactions, predicts the Y/U/V writes and the frame status, and checks each result.
// Depends on nvc_pkg only.
`timescale 1ns / 1ps
module nvc_frame_checker
  import nvc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [BYTE_W-1:0]     in_pixel_byte,
  input  wire logic                  in_is_final,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [1:0]            out_plane,
  input  wire logic [LOFF_W-1:0]     out_dest_offset,
  input  wire logic [BYTE_W-1:0]     out_out_byte,
  input  wire logic                  out_end_of_frame,
  input  wire logic [1:0]            out_status,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         writes_seen,
  output int                         frames_ok,
  output int                         frames_bad,
  output int                         frames_short
);

  // Shadow of the geometry registers, truncated to their widths
  logic [DIM_W-1:0]    coded_w;
  logic [DIM_W-1:0]    coded_h;
  logic [STRIDE_W-1:0] luma_pitch;
  logic [STRIDE_W-1:0] chroma_pitch;
  logic [DIM_W-1:0]    crop_w;
  logic [DIM_W-1:0]    crop_h;

  // Source position and destination cursors
  phase_t              phase;
  logic [DIM_W-1:0]    row;
  logic [STRIDE_W-1:0] col;
  logic [LOFF_W-1:0]   y_addr;
  logic [COFF_W-1:0]   uv_addr;

  res_t                planned_writes[$];

  function automatic bit geometry_legal();
    if (coded_w == '0 || coded_h == '0 || crop_w == '0 || crop_h == '0) return 1'b0;
    if (coded_w[0] | coded_h[0] | crop_w[0] | crop_h[0]) return 1'b0;
    if (crop_w > coded_w || crop_h > coded_h) return 1'b0;
    if (luma_pitch < coded_w || chroma_pitch < coded_w) return 1'b0;
    if (coded_w > MAX_DIM || coded_h > MAX_DIM) return 1'b0;
    if (luma_pitch > MAX_STRIDE || chroma_pitch > MAX_STRIDE) return 1'b0;
    return 1'b1;
  endfunction

  function automatic res_t make_res(input logic [1:0] pl, input logic [LOFF_W-1:0] off,
                                    input logic [BYTE_W-1:0] data, input logic eof,
                                    input logic [1:0] st);
    res_t r;
    r.plane        = pl;
    r.dest_offset  = off;
    r.out_byte     = data;
    r.end_of_frame = eof;
    r.status       = st;
    return r;
  endfunction

  task automatic rewind();
    phase   = PH_LUMA;
    row     = '0;
    col     = '0;
    y_addr  = '0;
    uv_addr = '0;
  endtask

  // Place one source byte and queue the writes it causes
  task automatic place_byte(input logic [BYTE_W-1:0] data, input logic last);
    if (!geometry_legal()) begin
      if (last) begin
        planned_writes.push_back(make_res(PLANE_NONE, '0, '0, 1'b1, ST_BAD));
        rewind();
      end
      return;
    end
    case (phase)
      PH_LUMA: begin
        if (row < crop_h && col < crop_w) begin
          planned_writes.push_back(make_res(PLANE_Y, y_addr, data, 1'b0, ST_OK));
          y_addr = y_addr + 1'b1;
        end
        col = col + 1'b1;
        if (col >= luma_pitch) begin
          col = '0;
          row = row + 1'b1;
          if (row >= coded_h) begin
            row   = '0;
            phase = PH_CHROMA;
          end
        end
      end
      PH_CHROMA: begin
        // Even columns carry U, odd columns V; advance the pair address after V
        if (row < (crop_h >> 1) && col < crop_w) begin
          if (!col[0]) begin
            planned_writes.push_back(make_res(PLANE_U, LOFF_W'(uv_addr), data, 1'b0, ST_OK));
          end else begin
            planned_writes.push_back(make_res(PLANE_V, LOFF_W'(uv_addr), data, 1'b0, ST_OK));
            uv_addr = uv_addr + 1'b1;
          end
        end
        col = col + 1'b1;
        if (col >= chroma_pitch) begin
          col = '0;
          row = row + 1'b1;
          if (row >= (coded_h >> 1)) begin
            row   = '0;
            phase = PH_DONE;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      planned_writes.push_back(make_res(PLANE_NONE, '0, '0, 1'b1,
                                        (phase == PH_DONE) ? ST_OK : ST_SHORT));
      rewind();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      coded_w      = '0;
      coded_h      = '0;
      luma_pitch   = '0;
      chroma_pitch = '0;
      crop_w       = '0;
      crop_h       = '0;
      rewind();
      planned_writes.delete();
      mismatches   = 0;
      writes_seen  = 0;
      frames_ok    = 0;
      frames_bad   = 0;
      frames_short = 0;
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CODED_WIDTH:   coded_w      = cfg_wdata[DIM_W-1:0];
          CFG_FRAME_ROWS:    coded_h      = cfg_wdata[DIM_W-1:0];
          CFG_LUMA_STRIDE:   luma_pitch   = cfg_wdata[STRIDE_W-1:0];
          CFG_CHROMA_STRIDE: chroma_pitch = cfg_wdata[STRIDE_W-1:0];
          CFG_CROP_COLS:     crop_w       = cfg_wdata[DIM_W-1:0];
          CFG_CROP_ROWS:     crop_h       = cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) place_byte(in_pixel_byte, in_is_final);

      // Compare each result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (planned_writes.size() == 0) begin
          $error("result with nothing expected: plane %0d offset %0d status %0d",
                 out_plane, out_dest_offset, out_status);
          mismatches++;
        end else begin
          want = planned_writes.pop_front();
          check_field("plane", want.plane, out_plane);
          check_field("dest_offset", want.dest_offset, out_dest_offset);
          check_field("out_byte", want.out_byte, out_out_byte);
          check_field("end_of_frame", want.end_of_frame, out_end_of_frame);
          check_field("status", want.status, out_status);
        end
        if (out_end_of_frame) begin
          case (out_status)
            ST_OK:    frames_ok++;
            ST_BAD:   frames_bad++;
            ST_SHORT: frames_short++;
            default: ;
          endcase
        end else begin
          writes_seen++;
        end
      end
    end
    outstanding = planned_writes.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Bench top for the NV12 to I420 crop converter: clock, reset, register setup, source
// and sink traffic, watchdog and verdict. Depends on nvc_pkg, the RTL and nvc_frame_checker.
`timescale 1ns / 1ps
module tb_top;
  import nvc_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_GAP      = 18;
  localparam int SINK_HOLD    = 250;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BYTES = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_pixel_byte;
  logic                  in_is_final;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_plane;
  logic [LOFF_W-1:0]     out_dest_offset;
  logic [BYTE_W-1:0]     out_out_byte;
  logic                  out_end_of_frame;
  logic [1:0]            out_status;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int writes_seen;
  int frames_ok;
  int frames_bad;
  int frames_short;

  bit src_burst  = 1'b0;
  bit sink_burst = 1'b0;
  bit hold_sink  = 1'b0;
  bit hold_done  = 1'b0;
  int idle_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  nv12_to_i420_crop_converter_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_byte    (in_pixel_byte),
    .in_is_final      (in_is_final),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plane        (out_plane),
    .out_dest_offset  (out_dest_offset),
    .out_out_byte     (out_out_byte),
    .out_end_of_frame (out_end_of_frame),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  nvc_frame_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_byte    (in_pixel_byte),
    .in_is_final      (in_is_final),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plane        (out_plane),
    .out_dest_offset  (out_dest_offset),
    .out_out_byte     (out_out_byte),
    .out_end_of_frame (out_end_of_frame),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .outstanding      (pending),
    .writes_seen      (writes_seen),
    .frames_ok        (frames_ok),
    .frames_bad       (frames_bad),
    .frames_short     (frames_short)
  );

  // Mostly short gaps, sometimes long ones; none at all while in a burst
  function automatic int draw_gap(input bit burst);
    if (burst) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_GAP) : $urandom_range(0, 1);
  endfunction

  // Offer one source transaction and hold it until accepted
  task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
    int gap;
    if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
    gap = draw_gap(src_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_pixel_byte = data;
    in_is_final   = last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send random bytes; the one at last_at carries the final flag
  task automatic send_run(input int unsigned count, input int unsigned last_at);
    for (int unsigned i = 0; i < count; i++) begin
      push_byte(BYTE_W'($urandom_range(0, 255)), i == last_at);
    end
  endtask

  // Drop valid, drain all predicted results, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_geometry(input int unsigned cw, input int unsigned ch,
                              input int unsigned ls, input int unsigned cs,
                              input int unsigned vw, input int unsigned vh);
    write_reg(CFG_CODED_WIDTH, CFG_DATA_W'(cw));
    write_reg(CFG_FRAME_ROWS, CFG_DATA_W'(ch));
    write_reg(CFG_LUMA_STRIDE, CFG_DATA_W'(ls));
    write_reg(CFG_CHROMA_STRIDE, CFG_DATA_W'(cs));
    write_reg(CFG_CROP_COLS, CFG_DATA_W'(vw));
    write_reg(CFG_CROP_ROWS, CFG_DATA_W'(vh));
    // Idle the register bus before traffic resumes
    repeat (2) @(negedge clk);
  endtask

  // Sink: random back-pressure, plus one long hold when requested
  initial begin : sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
      gap = draw_gap(sink_burst);
      @(negedge clk);
      if (hold_sink && !hold_done) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (SINK_HOLD) @(negedge clk);
      end else if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[nv12_to_i420_crop_converter_top] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned cw, ch, ls, cs, vw, vh;
    int unsigned frame_len, count, last_at, kind, source_bytes;
    bit          held;
    in_valid      = 1'b0;
    in_pixel_byte = '0;
    in_is_final   = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_CODED_WIDTH;
    cfg_wdata     = '0;
    source_bytes  = 0;
    held          = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Registers still at reset: geometry illegal, only the final byte reports
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b1);
    settle();

    // Smallest frame without padding: last chroma byte is a V write plus the status
    set_geometry(4, 2, 4, 4, 4, 2);
    for (int i = 0; i < 12; i++) push_byte(i[0] ? 8'hFF : 8'h00, i == 11);

    // Each illegal geometry rejects the frame on its final byte
    for (int i = 0; i < 7; i++) begin
      settle();
      case (i)
        0:       set_geometry(3, 2, 4, 4, 2, 2);
        1:       set_geometry(4, 2, 4, 4, 6, 2);
        2:       set_geometry(4, 2, 2, 4, 4, 2);
        3:       set_geometry(4098, 2, 8192, 8192, 4, 2);
        4:       set_geometry(4, 2, 4, 8194, 4, 2);
        5:       set_geometry(4, 0, 4, 4, 4, 2);
        default: set_geometry(16383, 16383, 16383, 16383, 16383, 16383);
      endcase
      push_byte(8'hC3, 1'b1);
    end

    // Largest legal geometry: a few luma writes, then a short-source status
    settle();
    set_geometry(4096, 4096, 8192, 8192, 4096, 4096);
    send_run(3, 2);

    // Random frames, mostly well formed
    while (source_bytes < RANDOM_BYTES) begin
      settle();
      kind = $urandom_range(0, 99);
      if (!held && source_bytes >= 400) begin
        // Dense frame with a long sink hold: the result queue fills and stalls the input
        held = 1'b1;
        set_geometry(32, 4, 32, 32, 32, 4);
        hold_sink = 1'b1;
        send_run(192, 191);
        source_bytes += 192;
      end else if (kind < 8) begin
        // Raw register values: almost always illegal, exercise every write data bit
        set_geometry($urandom_range(0, 16383), $urandom_range(0, 16383),
                     $urandom_range(0, 16383), $urandom_range(0, 16383),
                     $urandom_range(0, 16383), $urandom_range(0, 16383));
        send_run($urandom_range(1, 4), $urandom_range(0, 4));
      end else if (kind < 11) begin
        // Near the size limits: only the head of the frame, then a short final
        set_geometry(4096, 4096, $urandom_range(4096, 8192), $urandom_range(4096, 8192),
                     2 * $urandom_range(1, 2048), 2 * $urandom_range(1, 2048));
        count = $urandom_range(1, 6);
        send_run(count, count - 1);
        source_bytes += count;
      end else begin
        if ($urandom_range(0, 29) == 0) begin
          cw = 2 * $urandom_range(8, 24);
          ch = 2;
        end else begin
          cw = 2 * $urandom_range(1, 6);
          ch = 2 * $urandom_range(1, 4);
        end
        ls = cw + $urandom_range(0, 3);
        cs = cw + $urandom_range(0, 3);
        vw = 2 * $urandom_range(1, cw / 2);
        vh = 2 * $urandom_range(1, ch / 2);
        set_geometry(cw, ch, ls, cs, vw, vh);
        frame_len = ls * ch + cs * (ch / 2);
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          count   = frame_len;
          last_at = count - 1;
        end else if (kind < 78) begin
          // Trailing bytes after the chroma plane
          count   = frame_len + $urandom_range(1, 5);
          last_at = count - 1;
        end else if (kind < 92) begin
          count   = $urandom_range(1, frame_len - 1);
          last_at = count - 1;
        end else begin
          // No final: counters stay mid-frame across the next reconfiguration
          count   = $urandom_range(1, frame_len);
          last_at = count;
        end
        send_run(count, last_at);
        source_bytes += count;
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("Streamed %0d random source bytes after the directed frames; %0d plane writes checked.",
             source_bytes, writes_seen);
    $display("Frame status seen: %0d ok, %0d bad geometry, %0d short source.",
             frames_ok, frames_bad, frames_short);
    if (mismatches == 0 && pending == 0) begin
      $display("[nv12_to_i420_crop_converter_top] OK");
    end else begin
      $display("[nv12_to_i420_crop_converter_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/nvc_pkg.sv
rtl/nvc_cfg.sv
rtl/nvc_ctr.sv
rtl/nvc_outq.sv
rtl/nv12_to_i420_crop_converter_top.sv
bench/nvc_frame_checker.sv
bench/tb_top.sv
